// File: src/poisson_inverse_cdf_sampler_defines.svh
// Assertion macros shared by the Poisson sampler RTL.
// Expects clk and rst_n in the scope where a macro is used; no other dependencies.
`ifndef POISSON_INVERSE_CDF_SAMPLER_DEFINES_SVH
`define POISSON_INVERSE_CDF_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define PICS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PICS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PICS_ASSERT(lbl, prop, msg)
`define PICS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: src/pics_pkg.sv
// Package for the Poisson inverse-CDF sampler: sizes, codes and the search-state type.
// No dependencies.
package pics_pkg;

  localparam int TABLE_DEPTH   = 32;
  localparam int FRACTION_BITS = 32;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LEN_W   = $clog2(TABLE_DEPTH + 1);
  localparam int STEPS   = $clog2(TABLE_DEPTH);

  localparam int SAMPLE_W      = 6;
  localparam int ENTRY_INDEX_W = 5;
  localparam int FIELD_W       = 32;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int TLEN_W        = 6;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'b0;

  // One draw in flight through the search chain.
  typedef struct packed {
    logic                   valid;
    logic                   done;
    logic [LEN_W-1:0]       res;
    logic [IDX_W-1:0]       lo;
    logic [IDX_W-1:0]       hi;
    logic [TABLE_DEPTH-1:0] lt;
  } search_t;

endpackage

// File: src/pics_entry_cell.sv
// One table entry of the Poisson sampler with its own comparator.
// Depends on pics_pkg.
module pics_entry_cell
  import pics_pkg::*;
(
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [FRACTION_BITS-1:0] wr_data,
  input  logic [FRACTION_BITS-1:0] uniform,
  output logic                     lt
);

  logic [FRACTION_BITS-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  assign lt = uniform < entry_r;

endmodule

// File: src/pics_step_cell.sv
// One halving step of the binary search, registered, for the Poisson sampler.
// Depends on pics_pkg and the shared assertion macros.
`include "poisson_inverse_cdf_sampler_defines.svh"
module pics_step_cell
  import pics_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  search_t s_in,
  output search_t s_out
);

  search_t          st_r;
  search_t          st_nxt;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] mid;

  always_comb begin
    sum    = {1'b0, s_in.lo} + {1'b0, s_in.hi};
    mid    = sum[IDX_W:1];
    st_nxt = s_in;
    // Once the interval is down to neighbours the step changes nothing.
    if (s_in.valid && !s_in.done && (mid != s_in.lo)) begin
      if (s_in.lt[mid]) begin
        st_nxt.hi = mid;
      end else begin
        st_nxt.lo = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign s_out = st_r;

  `PICS_ASSERT(a_interval_open, st_r.valid && !st_r.done |-> st_r.lo < st_r.hi, "search interval collapsed")
  `PICS_ASSERT(a_res_range, st_r.valid && st_r.done |-> st_r.res <= LEN_W'(TABLE_DEPTH), "result beyond table")
  `PICS_ASSERT(a_hold, !adv |=> $stable(st_r), "step moved while the chain was held")

endmodule

// File: src/poisson_inverse_cdf_sampler.sv
// Top level of the Poisson inverse-CDF sampler: table cells, search chain, APB register.
// Depends on pics_pkg, pics_entry_cell, pics_step_cell and the assertion macros.
//
//   channel | ports                         | beat carries
//   --------+-------------------------------+-----------------------------------------
//   in      | in_valid / in_stall           | kind, entry_index, entry_value, uniform
//   out     | out_valid / out_stall         | sample (draw beats only)
//   cfg     | psel penable pwrite paddr ... | table_length at byte address 0
//
// Every input beat is taken at the front; a load writes its table cell at once and
// leaves nothing behind. A draw compares its fraction against all table cells in that same
// cycle and is captured in the front register at the accepting edge. It then walks the chain
// of STEPS halving cells, one cell after another, and its sample reaches the output from the
// last halving cell. One beat per cycle can enter and leave while the output is not held.
// The whole chain moves as one: a held output beat holds every stage and raises in_stall.
// Reset is synchronous and clears the stage valid bits and table_length; the table cells
// are not cleared and must be loaded before a draw reads them.
`include "poisson_inverse_cdf_sampler_defines.svh"
module poisson_inverse_cdf_sampler
  import pics_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic [ENTRY_INDEX_W-1:0] in_entry_index,
  input  logic [FIELD_W-1:0]       in_entry_value,
  input  logic [FIELD_W-1:0]       in_uniform,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SAMPLE_W-1:0]      out_sample,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready
);

  logic [TLEN_W-1:0]        table_length_r;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic                     cfg_write;

  logic                     adv;
  logic                     in_accept;
  logic                     load_ok;
  logic [FRACTION_BITS-1:0] wr_data;
  logic [FRACTION_BITS-1:0] uniform;
  logic [TABLE_DEPTH-1:0]   lt_vec;
  logic [LEN_W-1:0]         used_len;
  logic [IDX_W-1:0]         hi0;

  search_t                  s0_r;
  search_t                  s0_nxt;
  search_t                  chain [0:STEPS];

  // Configuration register. Writes must come only while idle; the block does not enforce this.
  assign pready    = 1'b1;
  assign cfg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_write && (cfg_index == REG_TABLE_LENGTH)) begin
      table_length_r <= pwdata[TLEN_W-1:0];
    end
  end

  assign prdata = (cfg_index == REG_TABLE_LENGTH) ? CFG_DATA_W'(table_length_r) : '0;

  // The chain advances unless a finished sample is being held at the output.
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;
  assign load_ok   = 32'(in_entry_index) < TABLE_DEPTH;
  assign wr_data   = FRACTION_BITS'(in_entry_value);
  assign uniform   = FRACTION_BITS'(in_uniform);

  // Table cells: each holds one entry and compares it with the incoming fraction.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_entry
    pics_entry_cell u_entry (
      .clk     (clk),
      .wr_en   (in_accept && (in_kind == KIND_LOAD) && load_ok &&
                (32'(in_entry_index) == i)),
      .wr_data (wr_data),
      .uniform (uniform),
      .lt      (lt_vec[i])
    );
  end

  // A length register above the table depth is treated as the full table.
  assign used_len = (32'(table_length_r) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH)
                                                       : LEN_W'(table_length_r);
  assign hi0      = IDX_W'(used_len - LEN_W'(1));

  // Front stage: the end checks of the search are settled here, and the compare
  // vector is captured so that later loads cannot disturb a draw in flight.
  always_comb begin
    s0_nxt       = '0;
    s0_nxt.valid = in_accept && (in_kind == KIND_DRAW);
    s0_nxt.lt    = lt_vec;
    s0_nxt.hi    = hi0;
    priority if (used_len == '0) begin
      s0_nxt.done = 1'b1;
    end else if (lt_vec[0]) begin
      s0_nxt.done = 1'b1;
    end else if (!lt_vec[hi0]) begin
      s0_nxt.done = 1'b1;
      s0_nxt.res  = used_len;
    end else begin
      s0_nxt.done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (adv) begin
      s0_r <= s0_nxt;
    end
  end

  assign chain[0] = s0_r;

  // Row of halving cells; each hands its draw to the next one every cycle while the chain advances.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    pics_step_cell u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .s_in  (chain[k]),
      .s_out (chain[k+1])
    );
  end

  // A draw that ran the full search ends with its answer in hi.
  assign out_valid  = chain[STEPS].valid;
  assign out_sample = SAMPLE_W'(chain[STEPS].done ? chain[STEPS].res
                                                  : LEN_W'(chain[STEPS].hi));

  `PICS_ASSERT(a_draw_enters, in_accept && in_kind == KIND_DRAW |=> s0_r.valid, "draw beat lost at the front")
  `PICS_ASSERT(a_load_no_result, in_accept && in_kind == KIND_LOAD |=> !s0_r.valid, "load beat produced a draw")
  `PICS_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid, "output valid after reset")

endmodule
